// ----- rtl/core/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// shared types and constants of the bilinear image scaler
// ----------------------------------------------------------------------------
package bis_pkg;

    // fixed field widths
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 10;
    localparam int STEP_W     = 26;
    localparam int STEP_BITS  = 16;
    localparam int PROD_W     = COORD_W + STEP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    // parameter defaults
    localparam int DEF_MAX_WIDTH     = 512;
    localparam int DEF_MAX_HEIGHT    = 512;
    localparam int DEF_FRACTION_BITS = 8;

    // depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register reset values
    localparam logic [SIZE_W-1:0] RST_SOURCE_SIZE = SIZE_W'(512);
    localparam logic [STEP_W-1:0] RST_STEP        = STEP_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH    = 2'd0,
        CFG_SOURCE_HEIGHT   = 2'd1,
        CFG_HORIZONTAL_STEP = 2'd2,
        CFG_VERTICAL_STEP   = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } t_command;

    typedef enum logic {
        BK_IDLE,
        BK_FETCH
    } t_back_state;

    // occupancy of the front pipeline
    typedef struct packed {
        logic s0_valid;
        logic s1_valid;
    } t_front_status;

endpackage

// ----- rtl/core/bis_ram.sv -----
// ----------------------------------------------------------------------------
// bis_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bis_front.sv -----
// ----------------------------------------------------------------------------
// bis_front
// takes requests, maps fetch coordinates to clamped source neighbours
// ----------------------------------------------------------------------------
module bis_front #(
    parameter int MAX_WIDTH     = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bis_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = bis_pkg::DEF_FRACTION_BITS,
    parameter int OP_W          = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_command,
    input  logic [bis_pkg::COORD_W-1:0]  i_row,
    input  logic [bis_pkg::COORD_W-1:0]  i_column,
    input  logic [bis_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic [bis_pkg::SIZE_W-1:0]   i_source_width,
    input  logic [bis_pkg::SIZE_W-1:0]   i_source_height,
    input  logic [bis_pkg::STEP_W-1:0]   i_horizontal_step,
    input  logic [bis_pkg::STEP_W-1:0]   i_vertical_step,
    output logic                         o_push,
    output logic [OP_W-1:0]              o_op,
    output bis_pkg::t_front_status       o_status
);

    import bis_pkg::*;

    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int BASE_W = PROD_W - STEP_BITS;

    typedef struct packed {
        logic                     fetch;
        logic [RW-1:0]            r0;
        logic [RW-1:0]            r1;
        logic [CW-1:0]            c0;
        logic [CW-1:0]            c1;
        logic [FRACTION_BITS-1:0] a;
        logic [FRACTION_BITS-1:0] b;
        logic [PIX_W-1:0]         pix;
    } t_op;

    // last usable index of an axis, size zero counts as one
    function automatic logic [COORD_W-1:0] clamp_last(input logic [SIZE_W-1:0] size,
                                                      input int unsigned max_size);
        if (size == '0) begin
            return '0;
        end
        if (32'(size) > max_size) begin
            return COORD_W'(max_size - 1);
        end
        return COORD_W'(size) - COORD_W'(1);
    endfunction

    function automatic logic [BASE_W-1:0] lo_index(input logic [BASE_W-1:0] base,
                                                   input logic [BASE_W-1:0] last);
        return (base > last) ? last : base;
    endfunction

    function automatic logic [BASE_W-1:0] hi_index(input logic [BASE_W-1:0] base,
                                                   input logic [BASE_W-1:0] last);
        return (base >= last) ? last : base + BASE_W'(1);
    endfunction

    // stage 0: captured request
    logic                r_s0_valid;
    logic                r_s0_cmd;
    logic [COORD_W-1:0]  r_s0_row;
    logic [COORD_W-1:0]  r_s0_col;
    logic [PIX_W-1:0]    r_s0_pix;

    // stage 1: source positions
    logic                r_s1_valid;
    logic                r_s1_cmd;
    logic [COORD_W-1:0]  r_s1_row;
    logic [COORD_W-1:0]  r_s1_col;
    logic [PIX_W-1:0]    r_s1_pix;
    logic [PROD_W-1:0]   r_s1_vpos;
    logic [PROD_W-1:0]   r_s1_hpos;

    logic [BASE_W-1:0]   last_r;
    logic [BASE_W-1:0]   last_c;
    logic [BASE_W-1:0]   base_r;
    logic [BASE_W-1:0]   base_c;
    logic [BASE_W-1:0]   idx_r0;
    logic [BASE_W-1:0]   idx_r1;
    logic [BASE_W-1:0]   idx_c0;
    logic [BASE_W-1:0]   idx_c1;
    logic                in_range;
    t_op                 op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_accept;
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s0_cmd <= i_command;
            r_s0_row <= i_row;
            r_s0_col <= i_column;
            r_s0_pix <= i_pixel_in;
        end
        if (r_s0_valid) begin
            r_s1_cmd  <= r_s0_cmd;
            r_s1_row  <= r_s0_row;
            r_s1_col  <= r_s0_col;
            r_s1_pix  <= r_s0_pix;
            r_s1_vpos <= PROD_W'(r_s0_row) * PROD_W'(i_vertical_step);
            r_s1_hpos <= PROD_W'(r_s0_col) * PROD_W'(i_horizontal_step);
        end
    end

    always_comb begin
        last_r   = BASE_W'(clamp_last(i_source_height, MAX_HEIGHT));
        last_c   = BASE_W'(clamp_last(i_source_width, MAX_WIDTH));
        base_r   = r_s1_vpos[PROD_W-1:STEP_BITS];
        base_c   = r_s1_hpos[PROD_W-1:STEP_BITS];
        idx_r0   = lo_index(base_r, last_r);
        idx_r1   = hi_index(base_r, last_r);
        idx_c0   = lo_index(base_c, last_c);
        idx_c1   = hi_index(base_c, last_c);
        in_range = (32'(r_s1_row) < MAX_HEIGHT) && (32'(r_s1_col) < MAX_WIDTH);

        op = '0;
        if (r_s1_cmd == CMD_FETCH) begin
            op.fetch = 1'b1;
            op.r0    = idx_r0[RW-1:0];
            op.r1    = idx_r1[RW-1:0];
            op.c0    = idx_c0[CW-1:0];
            op.c1    = idx_c1[CW-1:0];
            op.a     = r_s1_vpos[STEP_BITS-1 -: FRACTION_BITS];
            op.b     = r_s1_hpos[STEP_BITS-1 -: FRACTION_BITS];
        end else begin
            op.r0  = r_s1_row[RW-1:0];
            op.c0  = r_s1_col[CW-1:0];
            op.pix = r_s1_pix;
        end
    end

    // loads outside the store are dropped here
    assign o_push            = r_s1_valid && ((r_s1_cmd == CMD_FETCH) || in_range);
    assign o_op              = op;
    assign o_status.s0_valid = r_s0_valid;
    assign o_status.s1_valid = r_s1_valid;

endmodule

// ----- rtl/core/bis_queue.sv -----
// ----------------------------------------------------------------------------
// bis_queue
// small request fifo between front and back
// ----------------------------------------------------------------------------
module bis_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = bis_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_head,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
        return (32'(ptr) == DEPTH - 1) ? '0 : ptr + PW'(1);
    endfunction

    assign do_push = i_push && (32'(r_count) < DEPTH);
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// ----- rtl/core/bis_back.sv -----
// ----------------------------------------------------------------------------
// bis_back
// runs queued loads and fetches against the frame store, blends neighbours
// ----------------------------------------------------------------------------
module bis_back #(
    parameter int MAX_WIDTH     = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bis_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = bis_pkg::DEF_FRACTION_BITS,
    parameter int OP_W          = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  logic [OP_W-1:0]            i_head,
    output logic                       o_pop,
    output logic                       o_result_valid,
    output logic [bis_pkg::PIX_W-1:0]  o_pixel_out
);

    import bis_pkg::*;

    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = FRACTION_BITS + 1;
    localparam int WT_W  = 2 * WW;
    localparam int ACC_W = 2 * FRACTION_BITS + PIX_W;
    localparam logic [1:0]    NBR_LAST   = 2'd3;
    localparam logic [WW-1:0] WEIGHT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic                     fetch;
        logic [RW-1:0]            r0;
        logic [RW-1:0]            r1;
        logic [CW-1:0]            c0;
        logic [CW-1:0]            c1;
        logic [FRACTION_BITS-1:0] a;
        logic [FRACTION_BITS-1:0] b;
        logic [PIX_W-1:0]         pix;
    } t_op;

    t_back_state r_state;
    t_back_state n_state;
    logic [1:0]  r_nbr;
    t_op         r_op;
    t_op         head_op;
    t_op         src_op;

    logic        pop;
    logic        ram_we;
    logic        issue;
    logic [1:0]  issue_k;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [AW-1:0] ram_addr;
    logic [PIX_W-1:0] ram_q;
    logic [WW-1:0] wy;
    logic [WW-1:0] wx;

    // read-data stage
    logic             r_d_valid;
    logic             r_d_first;
    logic             r_d_last;
    logic [WT_W-1:0]  r_wt;
    // product stage
    logic             r_p_valid;
    logic             r_p_first;
    logic             r_p_last;
    logic [ACC_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] acc_sum;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;

    assign head_op = i_head;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && head_op.fetch) begin
                    n_state = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (r_nbr == NBR_LAST) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        pop     = 1'b0;
        ram_we  = 1'b0;
        issue   = 1'b0;
        issue_k = r_nbr;
        src_op  = r_op;
        unique case (r_state)
            BK_IDLE: begin
                src_op  = head_op;
                issue_k = 2'd0;
                if (!i_empty) begin
                    pop = 1'b1;
                    if (head_op.fetch) begin
                        issue = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            BK_FETCH: begin
                issue = 1'b1;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    // neighbour order: upper-left, upper-right, lower-left, lower-right
    always_comb begin
        sel_row  = issue_k[1] ? src_op.r1 : src_op.r0;
        sel_col  = issue_k[0] ? src_op.c1 : src_op.c0;
        ram_addr = AW'(AW'(sel_row) * AW'(MAX_WIDTH)) + AW'(sel_col);
        wy       = issue_k[1] ? WW'(src_op.a) : WEIGHT_ONE - WW'(src_op.a);
        wx       = issue_k[0] ? WW'(src_op.b) : WEIGHT_ONE - WW'(src_op.b);
    end

    bis_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (src_op.pix),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_nbr       <= '0;
            r_d_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_d_valid   <= issue;
            r_p_valid   <= r_d_valid;
            r_out_valid <= r_p_valid && r_p_last;
            if (issue) begin
                r_nbr <= issue_k + 2'd1;
            end
        end
    end

    assign acc_sum = (r_p_first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (pop && head_op.fetch) begin
            r_op <= head_op;
        end
        if (issue) begin
            r_d_first <= (issue_k == 2'd0);
            r_d_last  <= (issue_k == NBR_LAST);
            r_wt      <= WT_W'(wy) * WT_W'(wx);
        end
        if (r_d_valid) begin
            r_p_first <= r_d_first;
            r_p_last  <= r_d_last;
            r_prod    <= ACC_W'(ram_q) * ACC_W'(r_wt);
        end
        if (r_p_valid) begin
            r_acc <= acc_sum;
            if (r_p_last) begin
                r_out_pix <= acc_sum[ACC_W-1 -: PIX_W];
            end
        end
    end

    assign o_pop          = pop;
    assign o_result_valid = r_out_valid;
    assign o_pixel_out    = r_out_pix;

endmodule

// ----- rtl/core/bilinear_image_scaler.sv -----
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// bilinear scaler for one 8-bit image plane with an on-chip frame store
// ----------------------------------------------------------------------------
// Requests are taken while busy is low. A load request writes one source
// pixel into the frame store and returns nothing; a fetch request returns one
// interpolated pixel on o_pixel_out, marked by o_result_valid for one cycle.
// With the queue empty and the store sequencer idle, a fetch passes
// through two front stages, the queue, four store reads and two blend
// stages before the strobe rises. There is no back-pressure on
// the result side: the receiver must take each result in the cycle it appears.
// The frame store is a single-port memory, so a fetch occupies it for four
// reads (one per neighbour) and a load for one; the next request waits until
// a fetch has issued its last read. Up to four requests wait in the queue
// between the coordinate front end and the store sequencer. The store is not
// cleared after reset: fetch only pixels that were loaded. Write the
// configuration registers only while no request is in flight.
module bilinear_image_scaler #(
    parameter int MAX_WIDTH     = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bis_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = bis_pkg::DEF_FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [bis_pkg::COORD_W-1:0]    i_row,
    input  logic [bis_pkg::COORD_W-1:0]    i_column,
    input  logic [bis_pkg::PIX_W-1:0]      i_pixel_in,
    // result side
    output logic                           o_result_valid,
    output logic [bis_pkg::PIX_W-1:0]      o_pixel_out,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bis_pkg::*;

    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int OP_W = 1 + 2 * RW + 2 * CW + 2 * FRACTION_BITS + PIX_W;

    // configuration registers
    logic [SIZE_W-1:0] r_source_width;
    logic [SIZE_W-1:0] r_source_height;
    logic [STEP_W-1:0] r_horizontal_step;
    logic [STEP_W-1:0] r_vertical_step;

    logic              accept;
    logic              push;
    logic [OP_W-1:0]   push_op;
    t_front_status     front_status;
    logic              pop;
    logic [OP_W-1:0]   head_op;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width    <= RST_SOURCE_SIZE;
            r_source_height   <= RST_SOURCE_SIZE;
            r_horizontal_step <= RST_STEP;
            r_vertical_step   <= RST_STEP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SOURCE_WIDTH:    r_source_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT:   r_source_height   <= i_cfg_data[SIZE_W-1:0];
                CFG_HORIZONTAL_STEP: r_horizontal_step <= i_cfg_data[STEP_W-1:0];
                CFG_VERTICAL_STEP:   r_vertical_step   <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // every request in the front pipe is guaranteed a queue slot
    assign busy   = (32'(q_count) + 32'(front_status.s0_valid) +
                     32'(front_status.s1_valid)) >= QUEUE_DEPTH;
    assign accept = start && !busy;

    // front: capture, coordinate mapping, edge clamping
    bis_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS),
        .OP_W          (OP_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_command         (i_command),
        .i_row             (i_row),
        .i_column          (i_column),
        .i_pixel_in        (i_pixel_in),
        .i_source_width    (r_source_width),
        .i_source_height   (r_source_height),
        .i_horizontal_step (r_horizontal_step),
        .i_vertical_step   (r_vertical_step),
        .o_push            (push),
        .o_op              (push_op),
        .o_status          (front_status)
    );

    // queue of classified requests
    bis_queue #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // back: frame store sequencing and weighted sum
    bis_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS),
        .OP_W          (OP_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_op),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_pixel_out    (o_pixel_out)
    );

    // a push into a full queue would lose a request
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && !pop && (32'(q_count) == QUEUE_DEPTH)))
        else $error("request queue overflow");

    // a fetch holds the store for four reads, so results never come back to back
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results on consecutive cycles");

    // an accepted request always enters the front pipe
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> front_status.s0_valid)
        else $error("accepted request not captured");

    // the queue never reports more entries than it holds
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(q_count) <= QUEUE_DEPTH)
        else $error("queue count out of range");

endmodule
